### src/assert_macros.svh
// Assertion helpers shared by the RTL.
// Each macro takes a label, clock, reset, antecedent, consequent and message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define VVE_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define VVE_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`else

`define VVE_ASSERT_IMP(lbl, ck, rs, ante, cons, msg)
`define VVE_ASSERT_NXT(lbl, ck, rs, ante, cons, msg)

`endif

`endif

### src/vve_pkg.sv
`default_nettype none

package vve_pkg;

  // Operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_UNSIGNED = 2'd0,
    OP_SIGNED   = 2'd1,
    OP_BOOL     = 2'd2,
    OP_FLOAT    = 2'd3
  } op_t;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Most bytes sent for one transaction
  localparam int MAX_BYTES = 10;
  localparam int IDX_W     = $clog2(MAX_BYTES);

  // One classified job: one or two varint words
  typedef struct packed {
    logic [63:0] first;
    logic [63:0] second;
    logic        two;
  } job_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

### src/vve_front.sv
`default_nettype none

module vve_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [1:0]    op,
  input  wire logic [63:0]   value,
  output logic               busy,
  input  wire logic          full,
  output logic               push,
  output vve_pkg::job_t      job
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_NORM,
    F_PUSH
  } fstate_t;

  fstate_t             state;
  logic [63:0]         word;
  logic                fin;
  logic                fsign;
  logic signed [11:0]  fexp;
  logic [63:0]         frac;

  logic                sgn;
  logic [10:0]         exf;
  logic [51:0]         frf;
  logic [63:0]         mag;
  logic [63:0]         smap;
  logic                is_sub;
  logic                is_fin;
  logic signed [12:0]  x;
  logic signed [12:0]  code;
  logic [12:0]         code_mag;
  logic [13:0]         cmap;
  logic [63:0]         rev;

  // Split the operand into float fields and build the signed map
  always_comb begin
    sgn    = value[63];
    exf    = value[62:52];
    frf    = value[51:0];
    mag    = sgn ? (~value + 64'd1) : value;
    smap   = {mag[62:0], sgn};
    is_sub = (vve_pkg::op_t'(op) == vve_pkg::OP_FLOAT) && (exf == '0) && (frf != '0);
    is_fin = (vve_pkg::op_t'(op) == vve_pkg::OP_FLOAT) && !(&exf) &&
             !((exf == '0) && (frf == '0));
  end

  // Exponent code of a finite float, then its signed map
  always_comb begin
    if (fexp < 0) begin
      x = (13'(fexp) <<< 1) - 13'(fsign);
    end else begin
      x = (13'(fexp) <<< 1) + 13'(fsign);
    end
    code     = (x < 0) ? (x - 13'sd2) : (x + 13'sd3);
    code_mag = (code < 0) ? 13'(-code) : 13'(code);
    cmap     = {code_mag, code[12]};
  end

  // Bit-reverse the normalized fraction
  always_comb begin
    for (int i = 0; i < 64; i++) begin
      rev[i] = frac[63 - i];
    end
  end

  // Present the job and push it once the queue has room
  always_comb begin
    busy = (state != F_IDLE);
    push = (state == F_PUSH) && !full;
    if (fin) begin
      job.first  = {50'd0, cmap};
      job.second = rev;
      job.two    = 1'b1;
    end else begin
      job.first  = word;
      job.second = '0;
      job.two    = 1'b0;
    end
  end

  // Accept and classify a transaction; normalize subnormals one bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (start) begin
            fin   <= is_fin;
            fsign <= sgn;
            state <= is_sub ? F_NORM : F_PUSH;
            case (vve_pkg::op_t'(op))
              vve_pkg::OP_UNSIGNED: word <= value;
              vve_pkg::OP_SIGNED:   word <= smap;
              vve_pkg::OP_BOOL:     word <= {63'd0, |value};
              default: begin
                if (&exf) begin
                  word <= (frf != '0) ? 64'd0 : (sgn ? 64'd3 : 64'd2);
                end else if (exf == '0 && frf == '0) begin
                  word <= sgn ? 64'd5 : 64'd4;
                end else if (exf != '0) begin
                  fexp <= $signed({1'b0, exf}) - 12'sd1022;
                  frac <= {1'b1, frf, 11'd0};
                end else begin
                  fexp <= -12'sd1021;
                  frac <= {1'b0, frf, 11'd0};
                end
              end
            endcase
          end
        end
        F_NORM: begin
          if (frac[63]) begin
            state <= F_PUSH;
          end else begin
            frac <= {frac[62:0], 1'b0};
            fexp <= fexp - 12'sd1;
          end
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/vve_queue.sv
`default_nettype none

module vve_queue #(
  parameter int DEPTH = vve_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire vve_pkg::job_t  wr_job,
  input  wire logic           pop,
  output vve_pkg::job_t       rd_job,
  output vve_pkg::q_stat_t    stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  vve_pkg::job_t     mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  // Report fill state and show the oldest job
  always_comb begin
    stat.full  = (count == CNT_W'(DEPTH));
    stat.empty = (count == '0);
    rd_job     = mem[rd_ptr];
  end

  // Store a pushed job
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  // Advance pointers and track the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### src/vve_back.sv
`default_nettype none

module vve_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire vve_pkg::job_t  job,
  input  wire logic           empty,
  output logic                pop,
  output logic                strobe,
  output logic [7:0]          out_byte,
  output logic                last
);

  logic                        active;
  logic [63:0]                 cur;
  logic [63:0]                 second;
  logic                        has2;
  logic [vve_pkg::IDX_W-1:0]   idx;

  logic                        more;
  logic                        done;

  // Decide the current byte and whether it closes the transaction
  always_comb begin
    more = |cur[63:7];
    done = (idx == vve_pkg::IDX_W'(vve_pkg::MAX_BYTES - 1)) || (!more && !has2);
    pop  = !empty && (!active || done);
  end

  // Emit one byte a cycle; load the next job as the last byte goes out
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe   <= active;
      out_byte <= more ? {1'b1, cur[6:0]} : cur[7:0];
      last     <= done;
      if (pop) begin
        active <= 1'b1;
        cur    <= job.first;
        second <= job.second;
        has2   <= job.two;
        idx    <= '0;
      end else if (active) begin
        if (done) begin
          active <= 1'b0;
        end
        if (more) begin
          cur <= {7'd0, cur[63:7]};
        end else begin
          cur  <= second;
          has2 <= 1'b0;
        end
        idx <= idx + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### src/varint_value_encoder.sv
// Channel   | Ports                    | Transaction
// ----------+--------------------------+------------------------------------
// input     | start, busy, op, value   | start high and busy low at clk edge
// result    | strobe, out_byte, last   | strobe marks each byte
//
// Bytes of a transaction leave one per cycle, and the emitter loads the next
// job with the last byte when the queue holds one; the front accepts a
// transaction in F_IDLE and pushes it from F_PUSH once the queue has room.
// A subnormal float first visits F_NORM, which shifts its fraction up to bit 63.
// Synchronous rst clears front, queue and emitter control; payload is not reset.
// The receiver cannot stall; busy holds off start while the front is occupied.
`default_nettype none
`include "assert_macros.svh"

module varint_value_encoder #(
  parameter int QUEUE_DEPTH = vve_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [1:0]   op,
  input  wire logic [63:0]  value,
  output logic              strobe,
  output logic [7:0]        out_byte,
  output logic              last
);

  vve_pkg::job_t     push_job;
  vve_pkg::job_t     pop_job;
  vve_pkg::q_stat_t  q_stat;
  logic              push;
  logic              pop;

  // Classify transactions
  vve_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .value (value),
    .busy  (busy),
    .full  (q_stat.full),
    .push  (push),
    .job   (push_job)
  );

  // Decouple front and back
  vve_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (push_job),
    .pop    (pop),
    .rd_job (pop_job),
    .stat   (q_stat)
  );

  // Emit varint bytes
  vve_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job      (pop_job),
    .empty    (q_stat.empty),
    .pop      (pop),
    .strobe   (strobe),
    .out_byte (out_byte),
    .last     (last)
  );

  // Bytes of one transaction go out back to back
  `VVE_ASSERT_NXT(a_bytes_contig, clk, rst, strobe && !last, strobe, "byte gap within transaction")
  // An accepted transaction occupies the front
  `VVE_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy, "front not busy after accept")
  // The queue never reports full and empty together
  `VVE_ASSERT_IMP(a_q_stat, clk, rst, q_stat.full, !q_stat.empty, "queue full and empty")

endmodule

`default_nettype wire
